// File: rtl/core/okl_pkg.sv
`timescale 1ns / 1ps

package okl_pkg;

    // field widths of the input and result words
    localparam int CMD_W       = 3;
    localparam int KEY_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 6;

    // packed word widths, padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam int DEF_CAPACITY = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 3'd0,
        CMD_DELETE   = 3'd1,
        CMD_RM_FRONT = 3'd2,
        CMD_RM_BACK  = 3'd3,
        CMD_DUMP     = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_MISS  = 2'd2,
        ST_ENTRY = 2'd3
    } status_t;

endpackage

// File: rtl/core/okl_ram.sv
`timescale 1ns / 1ps

// simple dual port ram, one write port, one read port with registered data
module okl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/ordered_key_list_engine_core.sv
`timescale 1ns / 1ps

// channel   direction  handshake          payload
// s_        in         s_tvalid/s_tready  s_tdata: command, key_value
// m_        out        m_tvalid/m_tready  m_tdata: status, entry_key, entry_count; m_tlast
//
// one command word at a time; remove front/back read the entry, insert and unused codes do not
// delete by key reads and compares each scanned entry, then reads and writes each entry
// moved to close the gap, all through the single read port of the entry ram
// dump reads each entry, then presents it as one result word
// aresetn clears count, head and control; the entry ram is not cleared and needs no sweep
// a stalled m_ side holds the engine in its result state, s_tready stays low meanwhile

module ordered_key_list_engine_core #(
    parameter int CAPACITY = okl_pkg::DEF_CAPACITY
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: [2:0] command, [34:3] key_value, [39:35] zero
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [okl_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: [1:0] status, [33:2] entry_key, [39:34] entry_count
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [okl_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);

    import okl_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW:0]   CAP_EXT = (AW + 1)'(CAPACITY);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_SRCH_RD  = 10'b00_0000_0010,
        S_SRCH_CMP = 10'b00_0000_0100,
        S_SHIFT_RD = 10'b00_0000_1000,
        S_SHIFT_WR = 10'b00_0001_0000,
        S_TAKE_RD  = 10'b00_0010_0000,
        S_TAKE     = 10'b00_0100_0000,
        S_DUMP_RD  = 10'b00_1000_0000,
        S_DUMP_OUT = 10'b01_0000_0000,
        S_RESP     = 10'b10_0000_0000
    } state_t;

    // circular buffer: logical position p lives at slot (head + p) mod CAPACITY
    function automatic logic [AW-1:0] slot_of(logic [AW-1:0] head, logic [AW-1:0] pos);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= CAP_EXT) begin
            sum = sum - CAP_EXT;
        end
        return sum[AW-1:0];
    endfunction

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [AW-1:0]           head_reg, head_next;
    logic [AW-1:0]           pos_reg, pos_next;
    cmd_t                    cmd_reg, cmd_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    status_t                 resp_st_reg, resp_st_next;
    logic signed [KEY_W-1:0] resp_key_reg, resp_key_next;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                    m_tlast_reg, m_tlast_next;

    // ram ports
    logic                    ram_wr_en;
    logic [AW-1:0]           ram_wr_addr;
    logic [KEY_W-1:0]        ram_wr_data;
    logic [AW-1:0]           rd_pos;
    logic [AW-1:0]           ram_rd_addr;
    logic [KEY_W-1:0]        ram_rd_data;

    logic                    s_fire;
    logic                    slot_free;
    logic                    pos_is_last;
    logic                    shift_is_last;
    logic                    list_empty;
    logic                    list_full;
    logic [AW-1:0]           head_dec;
    logic [AW-1:0]           head_inc;
    cmd_t                    s_cmd;
    logic signed [KEY_W-1:0] s_key;

    assign s_cmd = cmd_t'(s_tdata[CMD_W-1:0]);
    assign s_key = s_tdata[CMD_W+KEY_W-1:CMD_W];

    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    // output register can take a new word this cycle
    assign slot_free = !m_tvalid_reg || m_tready;

    assign list_empty    = (count_reg == '0);
    assign list_full     = (count_reg >= CAP_CNT);
    assign pos_is_last   = ((CW'(pos_reg) + CW'(1)) == count_reg);
    assign shift_is_last = ((CW'(pos_reg) + CW'(2)) == count_reg);
    assign head_dec      = (head_reg == '0) ? LAST_SLOT : head_reg - AW'(1);
    assign head_inc      = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);

    // shift reads one ahead of the slot it writes
    assign rd_pos      = (state_reg == S_SHIFT_RD) ? pos_reg + AW'(1) : pos_reg;
    assign ram_rd_addr = slot_of(head_reg, rd_pos);

    okl_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        pos_next      = pos_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        resp_st_next  = resp_st_reg;
        resp_key_next = resp_key_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = slot_of(head_reg, pos_reg);
        ram_wr_data   = ram_rd_data;

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    cmd_next      = s_cmd;
                    key_next      = s_key;
                    pos_next      = '0;
                    resp_key_next = '0;
                    resp_st_next  = ST_DONE;
                    state_next    = S_RESP;
                    unique case (s_cmd)
                        CMD_INSERT: begin
                            if (list_full) begin
                                resp_st_next = ST_FULL;
                            end else begin
                                // new front goes one slot below the old head
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = head_dec;
                                ram_wr_data = s_key;
                                head_next   = head_dec;
                                count_next  = count_reg + CW'(1);
                            end
                        end
                        CMD_DELETE: begin
                            if (list_empty) begin
                                resp_st_next = ST_MISS;
                            end else begin
                                state_next = S_SRCH_RD;
                            end
                        end
                        CMD_RM_FRONT, CMD_RM_BACK: begin
                            if (list_empty) begin
                                resp_st_next = ST_MISS;
                            end else begin
                                if (s_cmd == CMD_RM_BACK) begin
                                    pos_next = AW'(count_reg - CW'(1));
                                end
                                state_next = S_TAKE_RD;
                            end
                        end
                        CMD_DUMP: begin
                            if (list_empty) begin
                                resp_st_next = ST_MISS;
                            end else begin
                                state_next = S_DUMP_RD;
                            end
                        end
                        default: begin
                            // unused codes leave the list alone
                        end
                    endcase
                end
            end
            S_SRCH_RD: begin
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (ram_rd_data == key_reg) begin
                    resp_st_next  = ST_DONE;
                    resp_key_next = key_reg;
                    if (pos_is_last) begin
                        count_next = count_reg - CW'(1);
                        state_next = S_RESP;
                    end else begin
                        state_next = S_SHIFT_RD;
                    end
                end else if (pos_is_last) begin
                    resp_st_next = ST_MISS;
                    state_next   = S_RESP;
                end else begin
                    pos_next   = pos_reg + AW'(1);
                    state_next = S_SRCH_RD;
                end
            end
            S_SHIFT_RD: begin
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                // move entry at pos+1 down into pos
                ram_wr_en = 1'b1;
                if (shift_is_last) begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESP;
                end else begin
                    pos_next   = pos_reg + AW'(1);
                    state_next = S_SHIFT_RD;
                end
            end
            S_TAKE_RD: begin
                state_next = S_TAKE;
            end
            S_TAKE: begin
                resp_st_next  = ST_DONE;
                resp_key_next = ram_rd_data;
                count_next    = count_reg - CW'(1);
                if (cmd_reg == CMD_RM_FRONT) begin
                    head_next = head_inc;
                end
                state_next = S_RESP;
            end
            S_DUMP_RD: begin
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                // read address is held, so the ram data stays put while stalled
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {COUNT_OUT_W'(count_reg), ram_rd_data, ST_ENTRY};
                    m_tlast_next  = pos_is_last;
                    if (pos_is_last) begin
                        state_next = S_IDLE;
                    end else begin
                        pos_next   = pos_reg + AW'(1);
                        state_next = S_DUMP_RD;
                    end
                end
            end
            S_RESP: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {COUNT_OUT_W'(count_reg), resp_key_reg, resp_st_reg};
                    m_tlast_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            head_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            head_reg     <= head_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        resp_st_reg  <= resp_st_next;
        resp_key_reg <= resp_key_next;
        m_tdata_reg  <= m_tdata_next;
        m_tlast_reg  <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // count never passes capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    // count moves by at most one per cycle
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CW'(1)) ||
            (count_reg == $past(count_reg) - CW'(1)))
        else $error("entry count jumped");

    // ram is written only by an insert or by the gap closing step
    a_write_src: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> (state_reg == S_IDLE) || (state_reg == S_SHIFT_WR))
        else $error("entry ram written outside insert or shift");

    // one command at a time
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("second command taken while busy");

endmodule

// File: bench/ordered_key_list_engine_core_test.sv
`timescale 1ns / 1ps

module ordered_key_list_engine_core_test;

    import okl_pkg::*;

    localparam int LIST_DEPTH  = DEF_CAPACITY;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 40;

    // command codes the block must ignore
    localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

    typedef struct {
        status_t                status;
        logic [KEY_W-1:0]       key;
        logic                   last;
        logic [COUNT_OUT_W-1:0] count;
    } list_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // list contents as the block should hold them, index 0 is the front
    logic [KEY_W-1:0] list_keys[$];
    list_result_t     pending_results[$];

    int  mismatches = 0;
    int  cycle_count = 0;
    int  hold_cycles = 0;
    int  stall_left = 0;
    bit  no_idle = 0;

    ordered_key_list_engine_core #(
        .CAPACITY(LIST_DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
    end

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        $display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
        mismatches++;
    endtask

    function automatic void push_result(status_t status, logic [KEY_W-1:0] key, logic last);
        list_result_t r;
        r.status = status;
        r.key    = key;
        r.last   = last;
        r.count  = COUNT_OUT_W'(list_keys.size());
        pending_results.push_back(r);
    endfunction

    // list behavior for one accepted command word
    function automatic void predict_list_op(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key);
        int               pos;
        int               n;
        logic [KEY_W-1:0] taken;
        pos = -1;
        n = list_keys.size();
        case (cmd)
            CMD_INSERT: begin
                if (n >= LIST_DEPTH) begin
                    push_result(ST_FULL, '0, 1'b1);
                end else begin
                    list_keys.push_front(key);
                    push_result(ST_DONE, '0, 1'b1);
                end
            end
            CMD_DELETE: begin
                // only the first match from the front goes
                for (int i = 0; i < n; i++) begin
                    if (pos < 0 && list_keys[i] == key) pos = i;
                end
                if (pos < 0) begin
                    push_result(ST_MISS, '0, 1'b1);
                end else begin
                    taken = list_keys[pos];
                    list_keys.delete(pos);
                    push_result(ST_DONE, taken, 1'b1);
                end
            end
            CMD_RM_FRONT, CMD_RM_BACK: begin
                if (n == 0) begin
                    push_result(ST_MISS, '0, 1'b1);
                end else begin
                    taken = (cmd == CMD_RM_FRONT) ? list_keys.pop_front()
                                                  : list_keys.pop_back();
                    push_result(ST_DONE, taken, 1'b1);
                end
            end
            CMD_DUMP: begin
                if (n == 0) begin
                    push_result(ST_MISS, '0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        push_result(ST_ENTRY, list_keys[i], i == n - 1);
                    end
                end
            end
            default: begin
                push_result(ST_DONE, '0, 1'b1);
            end
        endcase
    endfunction

    // prediction first, then the check, so a same-edge result still finds its entry
    always @(posedge aclk) begin : monitor
        list_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_list_op(s_tdata[CMD_W-1:0], s_tdata[CMD_W+KEY_W-1:CMD_W]);
            end
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("word with nothing pending", '0, {m_tlast, m_tdata});
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata[1:0] != want.status)
                        report_mismatch("status", want.status, m_tdata[1:0]);
                    if (m_tdata[33:2] != want.key)
                        report_mismatch("entry_key", want.key, m_tdata[33:2]);
                    if (m_tlast != want.last)
                        report_mismatch("tlast", want.last, m_tlast);
                    if (m_tdata[39:34] != want.count)
                        report_mismatch("entry_count", want.count, m_tdata[39:34]);
                end
            end
        end
    end

    // result side ready: long hold on request, else random stalls
    initial begin
        int r;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready = 1'b0;
                hold_cycles--;
            end else if (no_idle) begin
                m_tready = 1'b1;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                r = $urandom_range(0, 99);
                if (r < 70)      stall_left = 0;
                else if (r < 92) stall_left = $urandom_range(1, 3);
                else if (r < 99) stall_left = $urandom_range(4, 10);
                else             stall_left = $urandom_range(20, 50);
            end
        end
    end

    // offer one command word and hold it until taken; tvalid stays high on return
    task automatic send_word(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {{(S_TDATA_W - CMD_W - KEY_W){1'b0}}, key, cmd};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic sender_gap();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) gap = 0;
        else if (r < 90)       gap = $urandom_range(1, 3);
        else if (r < 98)       gap = $urandom_range(4, 12);
        else                   gap = $urandom_range(20, 60);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // sender pauses until every pending result has come back
    task automatic wait_list_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // mostly keys already held or a few small values, so deletes hit and duplicates occur
    function automatic logic [KEY_W-1:0] pick_key(bit from_list);
        int r;
        r = $urandom_range(0, 99);
        if (from_list && list_keys.size() > 0 && r < 60)
            return list_keys[$urandom_range(0, list_keys.size() - 1)];
        if (r < 80)
            return KEY_W'($urandom_range(0, 6)) - KEY_W'(3);
        return $urandom;
    endfunction

    task automatic test_directed_cases();
        // dump, both removes and delete on an empty list
        send_word(CMD_DUMP, '0);
        send_word(CMD_RM_FRONT, '0);
        send_word(CMD_RM_BACK, '0);
        send_word(CMD_DELETE, 32'h0000_0000);
        // key extremes, with a duplicate of the most negative key
        send_word(CMD_INSERT, 32'h7fff_ffff);
        send_word(CMD_INSERT, 32'h8000_0000);
        send_word(CMD_INSERT, 32'h0000_0000);
        send_word(CMD_INSERT, 32'hffff_ffff);
        send_word(CMD_INSERT, 32'h8000_0000);
        send_word(CMD_DUMP, '0);
        // first match only, then a key that is absent
        send_word(CMD_DELETE, 32'h8000_0000);
        send_word(CMD_DELETE, 32'h1234_5678);
        send_word(CMD_RM_FRONT, 32'hffff_ffff);
        send_word(CMD_RM_BACK, 32'hffff_ffff);
        // unused codes change nothing
        for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++) begin
            send_word(CMD_W'(c), 32'hffff_ffff);
        end
        send_word(CMD_DUMP, '0);
        send_word(CMD_INSERT, 32'h5555_5555);
        send_word(CMD_INSERT, 32'haaaa_aaaa);
        send_word(CMD_DELETE, 32'h8000_0000);
        send_word(CMD_DELETE, 32'h5555_5555);
        send_word(CMD_RM_BACK, '0);
        send_word(CMD_DELETE, 32'haaaa_aaaa);
        send_word(CMD_DUMP, '0);
        wait_list_idle();
    endtask

    task automatic test_fill_and_refuse();
        int needed;
        int left;
        int r;
        needed = LIST_DEPTH - list_keys.size();
        for (int i = 0; i < needed; i++) begin
            send_word(CMD_INSERT, pick_key(1'b0));
            sender_gap();
        end
        // inserts on a full list are refused
        repeat (3) begin
            send_word(CMD_INSERT, $urandom);
            sender_gap();
        end
        send_word(CMD_DUMP, '0);
        wait_list_idle();
        // open one slot in the middle, refill it, dump at full depth
        send_word(CMD_DELETE, list_keys[LIST_DEPTH / 2]);
        send_word(CMD_INSERT, $urandom);
        send_word(CMD_INSERT, $urandom);
        send_word(CMD_DUMP, '0);
        wait_list_idle();
        // drain from both ends and by key until empty, then hit the empty list
        left = list_keys.size();
        while (left > 0) begin
            r = $urandom_range(0, 2);
            if (r == 0) begin
                send_word(CMD_RM_FRONT, $urandom);
            end else if (r == 1) begin
                send_word(CMD_RM_BACK, $urandom);
            end else begin
                wait_list_idle();
                send_word(CMD_DELETE, list_keys[$urandom_range(0, list_keys.size() - 1)]);
            end
            left--;
            sender_gap();
        end
        send_word(CMD_RM_FRONT, '0);
        send_word(CMD_RM_BACK, '0);
        send_word(CMD_DUMP, '0);
        wait_list_idle();
    endtask

    task automatic test_random_mix(int n_items);
        int r;
        int n;
        int ins_w;
        for (int i = 0; i < n_items; i++) begin
            no_idle = (i >= n_items / 3 && i < n_items / 3 + 40);
            n = list_keys.size();
            ins_w = (n < 8) ? 55 : (n > 26) ? 25 : 38;
            r = $urandom_range(0, 99);
            if (r < ins_w)           send_word(CMD_INSERT, pick_key(1'b1));
            else if (r < ins_w + 24) send_word(CMD_DELETE, pick_key(1'b1));
            else if (r < ins_w + 35) send_word(CMD_RM_FRONT, $urandom);
            else if (r < ins_w + 46) send_word(CMD_RM_BACK, $urandom);
            else if (r < ins_w + 56) send_word(CMD_DUMP, $urandom);
            else send_word(CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)), $urandom);
            sender_gap();
            if (i % 60 == 59) wait_list_idle();
        end
        no_idle = 1'b0;
        wait_list_idle();
    endtask

    // receiver holds off while words keep coming, so the block backs up its input
    task automatic test_output_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 10; i++) begin
            send_word(CMD_INSERT, $urandom);
        end
        send_word(CMD_DUMP, '0);
        send_word(CMD_RM_BACK, '0);
        wait_list_idle();
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        repeat (2) @(negedge aclk);

        test_directed_cases();
        test_fill_and_refuse();
        test_output_backpressure();
        test_random_mix(260);

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
